>>> src/clcf_pkg.sv
// Shared types and constants of the calibrated loop current filter.
// Used by the channel interfaces, the serial arithmetic units and the top level.
package clcf_pkg;

   // Field widths
   localparam int CH_W       = 4;
   localparam int RAW_W      = 16;
   localparam int VAL_W      = 26;
   localparam int GAIN_W     = 18;
   localparam int OFFSET_W   = 22;
   localparam int TALLY_W    = 16;
   localparam int DEPTH_W    = 8;
   localparam int REF_W      = 22;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 22;

   // Fixed point formats and parameter defaults
   localparam int GAIN_FRAC         = 16;
   localparam int LOOP_CHANNELS_DEF = 12;
   localparam int FRAC_BITS_DEF     = 16;

   // Channel codes
   localparam logic [CH_W-1:0] REF_CHANNEL = 4'd14;
   localparam logic [CH_W-1:0] GND_CHANNEL = 4'd15;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SMOOTHING_DEPTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_EXPECTED    = 2'd1;

   // Scaling: current = (raw*25*2^frac + SCALE_RND) / SCALE_DIV
   localparam logic [RAW_W-1:0] SCALE_DIV = 16'd65535;
   localparam int               SCALE_RND = 32767;
   localparam int               GAIN_RND  = 32768;

   // Reset values and limits
   localparam logic [GAIN_W-1:0]   GAIN_RST   = 18'd65351;
   localparam logic [GAIN_W-1:0]   GAIN_MAX   = 18'h3FFFF;
   localparam logic [OFFSET_W-1:0] OFFSET_MAX = 22'h3FFFFF;
   localparam logic [TALLY_W-1:0]  TALLY_MAX  = 16'hFFFF;
   localparam logic [DEPTH_W-1:0]  DEPTH_RST  = 8'd3;
   localparam logic [REF_W-1:0]    REF_RST    = 22'd163840;
   localparam logic signed [VAL_W-1:0] VAL_MAX = 26'sh1FFFFFF;
   localparam logic signed [VAL_W-1:0] VAL_MIN = -26'sh2000000;
   localparam int                  RST_MA     = 4;

   // Status of a serial arithmetic unit
   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

endpackage

>>> src/clcf_if.sv
// Valid/ready channel interfaces of the calibrated loop current filter.
// Depends on clcf_pkg for the field widths.
interface clcf_req_if ();
   logic                        valid;
   logic                        ready;
   logic [clcf_pkg::CH_W-1:0]   channel;
   logic [clcf_pkg::RAW_W-1:0]  raw_sample;
   logic                        timed_out;

   modport source (output valid, channel, raw_sample, timed_out, input ready);
   modport sink   (input valid, channel, raw_sample, timed_out, output ready);
endinterface

interface clcf_rsp_if ();
   logic                              valid;
   logic                              ready;
   logic [clcf_pkg::CH_W-1:0]         channel_out;
   logic signed [clcf_pkg::VAL_W-1:0] filtered_current;
   logic                              updated;
   logic [clcf_pkg::TALLY_W-1:0]      failure_count;

   modport source (output valid, channel_out, filtered_current, updated, failure_count,
                   input ready);
   modport sink   (input valid, channel_out, filtered_current, updated, failure_count,
                   output ready);
endinterface

>>> src/clcf_serial_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on clcf_pkg for the unit status struct.
module clcf_serial_div #(
   parameter int N     = 39,
   parameter int D     = 21,
   parameter int QW    = 26,
   parameter int CNT_W = 5
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [CNT_W-1:0]        count,
   input  logic [D-1:0]            rem_init,
   input  logic [N-1:0]            bits,
   input  logic [D-1:0]            divisor,
   output clcf_pkg::unit_stat_type stat,
   output logic [QW-1:0]           quotient
);

   logic [D-1:0]     rem_ff, rem_in;
   logic [N-1:0]     bits_ff, bits_in;
   logic [D-1:0]     dvs_ff, dvs_in;
   logic [QW-1:0]    quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [D:0]       r2;
   logic [D:0]       trial;
   logic             ge;

   // trial subtract; the remainder stays below the divisor so r2 < 2*divisor
   always_comb begin
      r2    = {rem_ff, bits_ff[N-1]};
      trial = r2 - {1'b0, dvs_ff};
      ge    = ~trial[D];
   end

   always_comb begin
      rem_in  = rem_ff;
      bits_in = bits_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = rem_init;
         bits_in = bits;
         dvs_in  = divisor;
         quo_in  = '0;
         cnt_in  = count;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? trial[D-1:0] : r2[D-1:0];
         bits_in = bits_ff << 1;
         quo_in  = {quo_ff[QW-2:0], ge};
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      bits_ff <= bits_in;
      dvs_ff  <= dvs_in;
      quo_ff  <= quo_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule

>>> src/clcf_serial_mul.sv
// Shift-add multiplier, one multiplier bit per cycle through a narrow adder.
// Depends on clcf_pkg for the unit status struct.
module clcf_serial_mul #(
   parameter int A_W = 21,
   parameter int B_W = 18
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [A_W-1:0]          a,
   input  logic [B_W-1:0]          b,
   output clcf_pkg::unit_stat_type stat,
   output logic [A_W+B_W-1:0]      product
);

   localparam int CNT_W = $clog2(B_W + 1);

   logic [A_W-1:0]     a_ff, a_in;
   logic [A_W+B_W-1:0] prod_ff, prod_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [A_W:0]       sum;

   // add the multiplicand into the upper half when the low bit is set, then shift
   always_comb begin
      sum = {1'b0, prod_ff[A_W+B_W-1:B_W]} + (prod_ff[0] ? {1'b0, a_ff} : '0);
   end

   always_comb begin
      a_in    = a_ff;
      prod_in = prod_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = a;
         prod_in = {{A_W{1'b0}}, b};
         cnt_in  = CNT_W'(B_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         prod_in = {sum, prod_ff[B_W-1:1]};
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      prod_ff <= prod_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign product   = prod_ff;

endmodule

>>> src/calibrated_loop_current_filter.sv
// Top level of the calibrated loop current filter.
// Depends on clcf_pkg, clcf_if, clcf_serial_div and clcf_serial_mul.
//
// Usage
//   req_chan carries one item: channel, raw_sample and timed_out. rsp_chan returns
//   exactly one item per request: channel_out, filtered_current, updated and
//   failure_count. csr_* writes smoothing_depth (index 0) or ref_expected (index 1);
//   write only while the block is idle.
// Sequencing
//   One item at a time. The shared serial divider computes one quotient bit per cycle
//   for the scaling (FRAC_BITS + 5 bits), the gain (18 bits) and the smoothing step
//   (26 bits); the serial multiplier does the gain correction. req_chan.ready rises
//   again with the result load, so a new item is taken only once the result of the
//   last one is loaded.
// Reset and stalls
//   Synchronous reset restores all filters to 4 mA, the gain to 1/1.002828, the
//   offset and the failure count to zero, and empties the output register. A stalled
//   receiver holds the result in the output register; the next item is still taken and
//   processed, and waits only at its own result until the register is free.
module calibrated_loop_current_filter #(
   parameter int LOOP_CHANNELS = clcf_pkg::LOOP_CHANNELS_DEF,
   parameter int FRAC_BITS     = clcf_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   clcf_req_if.sink                          req_chan,
   clcf_rsp_if.source                        rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [clcf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [clcf_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   // field widths and the widths that follow from the fraction width
   localparam int CH_W     = clcf_pkg::CH_W;
   localparam int RAW_W    = clcf_pkg::RAW_W;
   localparam int VAL_W    = clcf_pkg::VAL_W;
   localparam int GAIN_W   = clcf_pkg::GAIN_W;
   localparam int OFFSET_W = clcf_pkg::OFFSET_W;
   localparam int TALLY_W  = clcf_pkg::TALLY_W;
   localparam int DEPTH_W  = clcf_pkg::DEPTH_W;
   localparam int REF_W    = clcf_pkg::REF_W;
   localparam int G_FRAC   = clcf_pkg::GAIN_FRAC;
   localparam int CUR_W    = FRAC_BITS + 5;
   localparam int R25_W    = RAW_W + 5;
   localparam int SCL_W    = R25_W + FRAC_BITS;
   localparam int GDV_W    = REF_W + G_FRAC + 1;
   localparam int DIV_N    = (SCL_W > GDV_W) ? SCL_W : GDV_W;
   localparam int DIV_D    = (CUR_W > RAW_W) ? CUR_W : RAW_W;
   localparam int QUO_W    = (CUR_W > VAL_W) ? CUR_W : VAL_W;
   localparam int CNT_W    = $clog2(QUO_W + 1);
   localparam int CMP_W    = (GDV_W > CUR_W + GAIN_W) ? GDV_W : CUR_W + GAIN_W;
   localparam int PRD_W    = CUR_W + GAIN_W;
   localparam int PRR_W    = PRD_W + 1 - G_FRAC;
   localparam int XA_W     = ((PRR_W > OFFSET_W) ? PRR_W : OFFSET_W) + 1;
   localparam int XD_W     = (XA_W > VAL_W + 1) ? XA_W : VAL_W + 1;
   localparam int OC_W     = (CUR_W > OFFSET_W) ? CUR_W : OFFSET_W;
   localparam int NS_W     = VAL_W + 2;
   localparam int LCH_W    = (LOOP_CHANNELS > 1) ? $clog2(LOOP_CHANNELS) : 1;

   localparam longint RST_FULL = longint'(clcf_pkg::RST_MA) << FRAC_BITS;
   localparam longint VMAX_L   = longint'(clcf_pkg::VAL_MAX);
   localparam logic signed [VAL_W-1:0] VAL_RST =
      VAL_W'((RST_FULL > VMAX_L) ? VMAX_L : RST_FULL);
   localparam logic signed [XD_W-1:0] XD_MAX = XD_W'(clcf_pkg::VAL_MAX);
   localparam logic signed [XD_W-1:0] XD_MIN = XD_W'(clcf_pkg::VAL_MIN);
   localparam logic signed [NS_W-1:0] NS_MAX = NS_W'(clcf_pkg::VAL_MAX);
   localparam logic signed [NS_W-1:0] NS_MIN = NS_W'(clcf_pkg::VAL_MIN);

   // sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_ISSUE = 4'd1;
   localparam logic [3:0] S_CUR   = 4'd2;
   localparam logic [3:0] S_DISP  = 4'd3;
   localparam logic [3:0] S_MUL   = 4'd4;
   localparam logic [3:0] S_XCALC = 4'd5;
   localparam logic [3:0] S_DIFF  = 4'd6;
   localparam logic [3:0] S_STEP  = 4'd7;
   localparam logic [3:0] S_GAIN  = 4'd8;
   localparam logic [3:0] S_OUT   = 4'd9;

   logic [3:0]                state_ff, state_in;
   logic [CH_W-1:0]           ch_ff;
   logic [RAW_W-1:0]          raw_ff;
   logic                      tmo_ff;
   logic [CUR_W-1:0]          cur_ff, cur_in;
   logic [PRR_W-1:0]          prr_ff, prr_in;
   logic signed [VAL_W-1:0]   x_ff, x_in;
   logic                      neg_ff, neg_in;
   logic                      upd_ff, upd_in;
   logic [GAIN_W-1:0]         gain_ff, gain_in;
   logic [OFFSET_W-1:0]       offset_ff, offset_in;
   logic [TALLY_W-1:0]        tally_ff, tally_in;
   logic [DEPTH_W-1:0]        depth_ff;
   logic [REF_W-1:0]          ref_ff;
   logic signed [VAL_W-1:0]   store_ff [LOOP_CHANNELS];
   logic                      store_we_in;
   logic signed [VAL_W-1:0]   store_wr_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_load;
   logic [CH_W-1:0]           rsp_ch_ff;
   logic signed [VAL_W-1:0]   rsp_filt_ff;
   logic                      rsp_upd_ff;
   logic [TALLY_W-1:0]        rsp_tally_ff;

   logic                      req_take;
   logic                      is_loop;
   logic [LCH_W-1:0]          rd_idx;
   logic signed [VAL_W-1:0]   f_cur;
   logic [R25_W-1:0]          raw25;
   logic [SCL_W-1:0]          scl;
   logic [GDV_W-1:0]          gdv;
   logic                      gsat;
   logic [PRD_W:0]            rnd;
   logic signed [XD_W-1:0]    xd;
   logic signed [VAL_W:0]     d_fwd;
   logic signed [VAL_W:0]     d_rev;
   logic [VAL_W-1:0]          mag;
   logic signed [NS_W-1:0]    f_ext;
   logic signed [NS_W-1:0]    q_ext;
   logic signed [NS_W-1:0]    nsum;

   logic                      div_start;
   logic [CNT_W-1:0]          div_count;
   logic [DIV_D-1:0]          div_rem;
   logic [DIV_N-1:0]          div_bits;
   logic [DIV_D-1:0]          div_dvs;
   clcf_pkg::unit_stat_type   div_stat;
   logic [QUO_W-1:0]          div_quo;
   logic                      mul_start;
   clcf_pkg::unit_stat_type   mul_stat;
   logic [PRD_W-1:0]          mul_prod;

   clcf_serial_div #(
      .N     (DIV_N),
      .D     (DIV_D),
      .QW    (QUO_W),
      .CNT_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .count    (div_count),
      .rem_init (div_rem),
      .bits     (div_bits),
      .divisor  (div_dvs),
      .stat     (div_stat),
      .quotient (div_quo)
   );

   clcf_serial_mul #(
      .A_W (CUR_W),
      .B_W (GAIN_W)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (cur_ff),
      .b       (gain_ff),
      .stat    (mul_stat),
      .product (mul_prod)
   );

   assign req_take = req_chan.valid && (state_ff == S_IDLE);

   // datapath around the sequencer
   always_comb begin
      is_loop = ch_ff < CH_W'(LOOP_CHANNELS);
      rd_idx  = is_loop ? ch_ff[LCH_W-1:0] : '0;
      f_cur   = store_ff[rd_idx];

      // raw * 25 as shifts, then scale to the current fraction with rounding
      raw25 = (R25_W'(raw_ff) << 4) + (R25_W'(raw_ff) << 3) + R25_W'(raw_ff);
      scl   = (SCL_W'(raw25) << FRAC_BITS) + SCL_W'(clcf_pkg::SCALE_RND);

      // reference: quotient saturates when the current is zero or dividend >= current * 2^18
      gdv  = (GDV_W'(ref_ff) << G_FRAC) + GDV_W'(cur_ff >> 1);
      gsat = (cur_ff == '0) || (CMP_W'(gdv) >= (CMP_W'(cur_ff) << GAIN_W));

      // round the gain product back to the current fraction
      rnd = {1'b0, mul_prod} + (PRD_W+1)'(clcf_pkg::GAIN_RND);
      xd  = $signed(XD_W'(prr_ff)) - $signed(XD_W'(offset_ff));

      // both directions of the difference, pick the magnitude
      d_fwd = $signed({x_ff[VAL_W-1], x_ff}) - $signed({f_cur[VAL_W-1], f_cur});
      d_rev = $signed({f_cur[VAL_W-1], f_cur}) - $signed({x_ff[VAL_W-1], x_ff});
      mag   = d_fwd[VAL_W] ? d_rev[VAL_W-1:0] : d_fwd[VAL_W-1:0];

      // step toward the new sample, truncated toward zero by dividing the magnitude
      f_ext = NS_W'(f_cur);
      q_ext = $signed({2'b00, div_quo[VAL_W-1:0]});
      nsum  = neg_ff ? (f_ext - q_ext) : (f_ext + q_ext);
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      prr_in       = prr_ff;
      x_in         = x_ff;
      neg_in       = neg_ff;
      upd_in       = upd_ff;
      gain_in      = gain_ff;
      offset_in    = offset_ff;
      tally_in     = tally_ff;
      store_we_in  = 1'b0;
      store_wr_in  = f_cur;
      div_start    = 1'b0;
      div_count    = '0;
      div_rem      = '0;
      div_bits     = '0;
      div_dvs      = '0;
      mul_start    = 1'b0;
      rsp_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: begin
            upd_in = 1'b0;
            if (tmo_ff) begin
               // count the failure, leave everything else alone
               if (tally_ff != clcf_pkg::TALLY_MAX) begin
                  tally_in = tally_ff + TALLY_W'(1);
               end
               state_in = S_OUT;
            end else if (is_loop || ch_ff == clcf_pkg::REF_CHANNEL ||
                         ch_ff == clcf_pkg::GND_CHANNEL) begin
               div_start = 1'b1;
               div_count = CNT_W'(CUR_W);
               div_rem   = DIV_D'(scl >> CUR_W);
               div_bits  = DIV_N'(scl[CUR_W-1:0]) << (DIV_N - CUR_W);
               div_dvs   = DIV_D'(clcf_pkg::SCALE_DIV);
               state_in  = S_CUR;
            end else begin
               state_in = S_OUT;
            end
         end
         S_CUR: begin
            if (div_stat.done) begin
               cur_in   = div_quo[CUR_W-1:0];
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            if (is_loop) begin
               mul_start = 1'b1;
               state_in  = S_MUL;
            end else if (ch_ff == clcf_pkg::REF_CHANNEL) begin
               if (gsat) begin
                  gain_in  = clcf_pkg::GAIN_MAX;
                  upd_in   = 1'b1;
                  state_in = S_OUT;
               end else begin
                  div_start = 1'b1;
                  div_count = CNT_W'(GAIN_W);
                  div_rem   = DIV_D'(gdv >> GAIN_W);
                  div_bits  = DIV_N'(gdv[GAIN_W-1:0]) << (DIV_N - GAIN_W);
                  div_dvs   = DIV_D'(cur_ff);
                  state_in  = S_GAIN;
               end
            end else begin
               // ground: the measured current becomes the offset
               if (OC_W'(cur_ff) > OC_W'(clcf_pkg::OFFSET_MAX)) begin
                  offset_in = clcf_pkg::OFFSET_MAX;
               end else begin
                  offset_in = OFFSET_W'(cur_ff);
               end
               upd_in   = 1'b1;
               state_in = S_OUT;
            end
         end
         S_MUL: begin
            if (mul_stat.done) begin
               prr_in   = rnd[PRD_W:G_FRAC];
               state_in = S_XCALC;
            end
         end
         S_XCALC: begin
            if (xd > XD_MAX) begin
               x_in = clcf_pkg::VAL_MAX;
            end else if (xd < XD_MIN) begin
               x_in = clcf_pkg::VAL_MIN;
            end else begin
               x_in = xd[VAL_W-1:0];
            end
            state_in = S_DIFF;
         end
         S_DIFF: begin
            neg_in    = d_fwd[VAL_W];
            div_start = 1'b1;
            div_count = CNT_W'(VAL_W);
            div_rem   = '0;
            div_bits  = DIV_N'(mag) << (DIV_N - VAL_W);
            div_dvs   = DIV_D'(depth_ff) + DIV_D'(1);
            state_in  = S_STEP;
         end
         S_STEP: begin
            if (div_stat.done) begin
               store_we_in = 1'b1;
               if (nsum > NS_MAX) begin
                  store_wr_in = clcf_pkg::VAL_MAX;
               end else if (nsum < NS_MIN) begin
                  store_wr_in = clcf_pkg::VAL_MIN;
               end else begin
                  store_wr_in = nsum[VAL_W-1:0];
               end
               upd_in   = 1'b1;
               state_in = S_OUT;
            end
         end
         S_GAIN: begin
            if (div_stat.done) begin
               gain_in  = div_quo[GAIN_W-1:0];
               upd_in   = 1'b1;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // hold here until the output register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control and shared state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         upd_ff       <= 1'b0;
         gain_ff      <= clcf_pkg::GAIN_RST;
         offset_ff    <= '0;
         tally_ff     <= '0;
         depth_ff     <= clcf_pkg::DEPTH_RST;
         ref_ff       <= clcf_pkg::REF_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         upd_ff       <= upd_in;
         gain_ff      <= gain_in;
         offset_ff    <= offset_in;
         tally_ff     <= tally_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               clcf_pkg::CSR_SMOOTHING_DEPTH: depth_ff <= csr_wdata[DEPTH_W-1:0];
               clcf_pkg::CSR_REF_EXPECTED:    ref_ff   <= csr_wdata[REF_W-1:0];
               default: begin
                  // drop writes beyond the register list
               end
            endcase
         end
      end
   end

   // per-channel filters restart at 4 mA
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LOOP_CHANNELS; i++) begin
            store_ff[i] <= VAL_RST;
         end
      end else if (store_we_in) begin
         store_ff[rd_idx] <= store_wr_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         ch_ff  <= req_chan.channel;
         raw_ff <= req_chan.raw_sample;
         tmo_ff <= req_chan.timed_out;
      end
      cur_ff <= cur_in;
      prr_ff <= prr_in;
      x_ff   <= x_in;
      neg_ff <= neg_in;
      if (rsp_load) begin
         rsp_ch_ff    <= ch_ff;
         rsp_filt_ff  <= is_loop ? f_cur : '0;
         rsp_upd_ff   <= upd_ff;
         rsp_tally_ff <= tally_ff;
      end
   end

   assign req_chan.ready            = (state_ff == S_IDLE);
   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.channel_out      = rsp_ch_ff;
   assign rsp_chan.filtered_current = rsp_filt_ff;
   assign rsp_chan.updated          = rsp_upd_ff;
   assign rsp_chan.failure_count    = rsp_tally_ff;

`ifndef SYNTHESIS
   // divider and multiplier never run together
   assert property (@(posedge clock) disable iff (reset)
      !(div_stat.busy && mul_stat.busy))
      else $error("divider and multiplier busy at once");

   // a divider result only arrives while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == S_CUR || state_ff == S_GAIN || state_ff == S_STEP))
      else $error("divider result arrived outside a divide state");

   // a new result is only ever loaded from the output state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("result valid raised outside the output state");
`endif

endmodule
